@@ src/m4vt_pkg.sv @@
`timescale 1ns / 1ps

package m4vt_pkg;

    // Default number of fraction bits of the signed fixed-point words.
    localparam int FRAC_BITS_DEFAULT = 16;

    localparam int WORD_W = 32;
    localparam int PROD_W = 2 * WORD_W;
    // Four products of two signed words need two extra bits.
    localparam int SUM_W  = PROD_W + 2;

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_MAT_VEC = 2'd1,
        KIND_VEC_MAT = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef word_t [3:0] vec4_t;
    typedef vec4_t [3:0] mat4_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    // One transform as queued between the front and the back: rows[i][j] is
    // the coefficient that multiplies vec[j] for result component i.
    typedef struct packed {
        mat4_t rows;
        vec4_t vec;
    } xfm_item_t;

endpackage

@@ src/m4vt_front.sv @@
`timescale 1ns / 1ps

module m4vt_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_kind,
    input  logic [1:0]           s_column,
    input  logic [1:0]           s_row,
    input  logic signed [31:0]   s_element,
    input  logic signed [31:0]   s_comp_x,
    input  logic signed [31:0]   s_comp_y,
    input  logic signed [31:0]   s_comp_z,
    input  logic signed [31:0]   s_comp_w,
    output logic                 push_valid,
    input  logic                 push_ready,
    output m4vt_pkg::xfm_item_t  push_item
);

    // Matrix store, entry column*4+row holds M[row][column].
    m4vt_pkg::word_t matrix_reg [16];

    logic       accept;
    logic       is_load;
    logic       is_xfm;
    logic       transpose;
    logic [3:0] wr_idx;

    always_comb begin
        is_load   = 1'b0;
        is_xfm    = 1'b0;
        transpose = 1'b0;
        unique case (s_kind)
            m4vt_pkg::KIND_LOAD: begin
                is_load = 1'b1;
            end
            m4vt_pkg::KIND_MAT_VEC: begin
                is_xfm = 1'b1;
            end
            m4vt_pkg::KIND_VEC_MAT: begin
                is_xfm    = 1'b1;
                transpose = 1'b1;
            end
            m4vt_pkg::KIND_NONE: begin
                is_xfm = 1'b0;
            end
        endcase
    end

    // Every word waits while the queue is full, so words leave in order.
    assign s_ready    = push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = s_valid && is_xfm;
    assign wr_idx     = {s_column, s_row};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 16; k++) begin
                matrix_reg[k] <= '0;
            end
        end else if (accept && is_load) begin
            matrix_reg[wr_idx] <= s_element;
        end
    end

    // The queued word carries a snapshot of the matrix, so later loads
    // cannot disturb a transform that is still waiting.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                if (transpose) begin
                    push_item.rows[i][j] = matrix_reg[i*4 + j];
                end else begin
                    push_item.rows[i][j] = matrix_reg[j*4 + i];
                end
            end
        end
        push_item.vec[0] = s_comp_x;
        push_item.vec[1] = s_comp_y;
        push_item.vec[2] = s_comp_z;
        push_item.vec[3] = s_comp_w;
    end

endmodule

@@ src/m4vt_queue.sv @@
`timescale 1ns / 1ps

module m4vt_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  m4vt_pkg::xfm_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output m4vt_pkg::xfm_item_t  out_item
);

    m4vt_pkg::xfm_item_t ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = ent_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ src/m4vt_back.sv @@
`timescale 1ns / 1ps

module m4vt_back #(
    parameter int FRAC_BITS = m4vt_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  m4vt_pkg::xfm_item_t  in_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_out_x,
    output logic signed [31:0]   m_out_y,
    output logic signed [31:0]   m_out_z,
    output logic signed [31:0]   m_out_w
);

    localparam int SUM_W  = m4vt_pkg::SUM_W;
    localparam int WORD_W = m4vt_pkg::WORD_W;

    m4vt_pkg::prod_t prod_reg [4][4];
    m4vt_pkg::sum_t  sum_reg [4];
    m4vt_pkg::sum_t  sum_next [4];
    m4vt_pkg::word_t res_reg [4];
    m4vt_pkg::word_t res_next [4];

    logic prod_v_reg, sum_v_reg, res_v_reg;
    logic prod_en, sum_en, res_en;

    // Saturates an arithmetically shifted sum to one signed word.
    function automatic m4vt_pkg::word_t sat_word(input m4vt_pkg::sum_t v);
        logic all_same;
        all_same = (v[SUM_W-1:WORD_W-1] == '0) || (v[SUM_W-1:WORD_W-1] == '1);
        if (all_same) begin
            sat_word = v[WORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            sat_word = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            sat_word = {1'b0, {(WORD_W-1){1'b1}}};
        end
    endfunction

    // A stage moves on when it is empty or when the stage after it moves.
    assign res_en   = !res_v_reg || m_ready;
    assign sum_en   = !sum_v_reg || res_en;
    assign prod_en  = !prod_v_reg || sum_en;
    assign in_ready = prod_en;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sum_next[i] = SUM_W'(prod_reg[i][0]) + SUM_W'(prod_reg[i][1])
                        + SUM_W'(prod_reg[i][2]) + SUM_W'(prod_reg[i][3]);
            // Arithmetic shift rounds toward minus infinity.
            res_next[i] = sat_word(sum_reg[i] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_v_reg <= 1'b0;
            sum_v_reg  <= 1'b0;
            res_v_reg  <= 1'b0;
        end else begin
            if (prod_en) begin
                prod_v_reg <= in_valid;
            end
            if (sum_en) begin
                sum_v_reg <= prod_v_reg;
            end
            if (res_en) begin
                res_v_reg <= sum_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_en && in_valid) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    prod_reg[i][j] <= $signed(in_item.rows[i][j]) * $signed(in_item.vec[j]);
                end
            end
        end
        if (sum_en && prod_v_reg) begin
            sum_reg <= sum_next;
        end
        if (res_en && sum_v_reg) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = res_v_reg;
    assign m_out_x = res_reg[0];
    assign m_out_y = res_reg[1];
    assign m_out_z = res_reg[2];
    assign m_out_w = res_reg[3];

endmodule

@@ src/matrix4_vector_transform.sv @@
`timescale 1ns / 1ps

// 4x4 matrix-vector transform in signed fixed point (FRAC_BITS fraction
// bits, Q16.16 by default). A load word writes one matrix element; a
// transform word multiplies its four-component vector either by the matrix
// as a column vector or, as a row vector, into the matrix, and returns one
// result word of four components. Each component is the exact sum of four
// products, shifted right by FRAC_BITS (rounding toward minus infinity) and
// saturated to 32 bits. The matrix clears to zero at reset. The block
// takes one word per clock cycle, sustained while m_ready does not hold
// the output back, loads and transforms mixed in any order; the figure
// is set by the sixteen parallel multipliers, which accept a new vector
// every cycle. A result passes the queue, product, sum and result registers.
// A load takes effect for every transform word accepted after it, since
// each queued transform carries its own copy of the matrix. Kind value 3
// is accepted and dropped without effect.
module matrix4_vector_transform #(
    parameter int FRAC_BITS = m4vt_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_kind,
    input  logic [1:0]          s_column,
    input  logic [1:0]          s_row,
    input  logic signed [31:0]  s_element,
    input  logic signed [31:0]  s_comp_x,
    input  logic signed [31:0]  s_comp_y,
    input  logic signed [31:0]  s_comp_z,
    input  logic signed [31:0]  s_comp_w,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_out_x,
    output logic signed [31:0]  m_out_y,
    output logic signed [31:0]  m_out_z,
    output logic signed [31:0]  m_out_w
);

    logic                q_push_valid;
    logic                q_push_ready;
    m4vt_pkg::xfm_item_t q_push_item;
    logic                q_pop_valid;
    logic                q_pop_ready;
    m4vt_pkg::xfm_item_t q_pop_item;

    // Front end: decodes the word, keeps the matrix and queues transforms.
    m4vt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_column   (s_column),
        .s_row      (s_row),
        .s_element  (s_element),
        .s_comp_x   (s_comp_x),
        .s_comp_y   (s_comp_y),
        .s_comp_z   (s_comp_z),
        .s_comp_w   (s_comp_w),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item)
    );

    // Two-entry queue that lets the front and back stall independently.
    m4vt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_push_valid),
        .in_ready  (q_push_ready),
        .in_item   (q_push_item),
        .out_valid (q_pop_valid),
        .out_ready (q_pop_ready),
        .out_item  (q_pop_item)
    );

    // Back end: products, sums, then shift and saturation into the
    // output register.
    m4vt_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_pop_valid),
        .in_ready (q_pop_ready),
        .in_item  (q_pop_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_out_x  (m_out_x),
        .m_out_y  (m_out_y),
        .m_out_z  (m_out_z),
        .m_out_w  (m_out_w)
    );

    // A load word must never reach the queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_kind == m4vt_pkg::KIND_LOAD)) |-> !q_push_valid)
        else $error("load word pushed into the transform queue");

    // The input side only stalls when the queue holds work for the back end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_pop_valid)
        else $error("input stalled while the queue is empty");

    // No result is offered in the cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    // A transform word accepted into an empty, unstalled block reaches the
    // back end in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push_valid && q_push_ready && !q_pop_valid) |=> q_pop_valid)
        else $error("queued transform word went missing");

endmodule
